FILE: rtl/assert_macros.svh
// assertion macros shared by the versioned snapshot array rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check held off while reset is high
`define VSA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds during reset
`define VSA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vsa_pkg.sv
// shared types and constants of the versioned snapshot array
// no dependencies; imported by vsa_seq, versioned_snapshot_array_unit and the testbench
package vsa_pkg;

   localparam int NUM_ENTRIES_DEF  = 1024;
   localparam int MAX_VERSIONS_DEF = 16;

   localparam int KIND_W  = 2;
   localparam int IDX_W   = 10;
   localparam int VAL_W   = 32;
   localparam int SNAP_W  = 16;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 11;
   localparam int LIM_W   = 17;
   localparam int HIST_W  = SNAP_W + VAL_W;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   localparam logic [LEN_W-1:0]  LEN_RESET = 11'd1024;
   localparam logic [SNAP_W-1:0] SNAP_MAX  = 16'hFFFF;
   localparam logic [VAL_W-1:0]  READ_FAIL = 32'hFFFF_FFFF;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SNAP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_SAT   = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [IDX_W-1:0]        entry_index;
      logic signed [VAL_W-1:0] write_value;
      logic [SNAP_W-1:0]       query_snapshot;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [SNAP_W-1:0]       snapshot_taken;
      logic [STAT_W-1:0]       status;
   } res_type;

endpackage

FILE: rtl/vsa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; used for the history store and the history counts
module vsa_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/vsa_seq.sv
// sequencer of the versioned snapshot array: clearing pass, snapshot counter, write update
// and binary search over one entry's history; uses vsa_pkg and assert_macros.svh
module vsa_seq #(
   parameter int NUM_ENTRIES  = vsa_pkg::NUM_ENTRIES_DEF,
   parameter int MAX_VERSIONS = vsa_pkg::MAX_VERSIONS_DEF,
   localparam int ENT_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
   localparam int VER_W   = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1,
   localparam int CNT_W   = $clog2(MAX_VERSIONS + 1),
   localparam int HIST_AW = ENT_W + VER_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  vsa_pkg::req_type              req,
   input  logic [vsa_pkg::LEN_W-1:0]     array_length,
   input  logic                          out_free,
   output logic                          res_valid,
   output vsa_pkg::res_type              res,
   output logic                          cnt_wr_en,
   output logic [ENT_W-1:0]              cnt_wr_addr,
   output logic [CNT_W-1:0]              cnt_wr_data,
   output logic [ENT_W-1:0]              cnt_rd_addr,
   input  logic [CNT_W-1:0]              cnt_rd_data,
   output logic                          hist_wr_en,
   output logic [HIST_AW-1:0]            hist_wr_addr,
   output logic [vsa_pkg::HIST_W-1:0]    hist_wr_data,
   output logic [HIST_AW-1:0]            hist_rd_addr,
   input  logic [vsa_pkg::HIST_W-1:0]    hist_rd_data
);

   import vsa_pkg::*;

`include "assert_macros.svh"

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_COUNT    = 3'd2;
   localparam logic [2:0] ST_WR_CHECK = 3'd3;
   localparam logic [2:0] ST_SEARCH   = 3'd4;
   localparam logic [2:0] ST_DONE     = 3'd5;

   localparam logic [LIM_W-1:0] NUM_ENT_LIM = LIM_W'(NUM_ENTRIES);
   localparam logic [ENT_W-1:0] LAST_ENTRY  = ENT_W'(NUM_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_VERSIONS);
   localparam logic [CNT_W-1:0] CNT_ONE     = CNT_W'(1);

   logic [2:0]        state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ENT_W-1:0]  entry_ff, entry_in;
   logic [VAL_W-1:0]  wval_ff, wval_in;
   logic [SNAP_W-1:0] query_ff, query_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [VER_W-1:0]  mid_ff, mid_in;
   logic              found_ff, found_in;
   logic [VAL_W-1:0]  hitval_ff, hitval_in;
   res_type           res_ff, res_in;
   logic [SNAP_W-1:0] snap_ff, snap_in;
   logic [ENT_W-1:0]  clr_ff, clr_in;

   logic [ENT_W+IDX_W-1:0] idx_wide;
   logic [ENT_W-1:0]       req_entry;
   logic [LIM_W-1:0]       len_ext;
   logic [LIM_W-1:0]       eff_len;
   logic                   in_range;
   logic                   accept;
   logic [SNAP_W-1:0]      rd_snap;
   logic [VAL_W-1:0]       rd_val;
   logic                   hit;
   logic [CNT_W-1:0]       lo_n, hi_n;
   logic [CNT_W:0]         mid_sum;
   logic [CNT_W:0]         first_sum;
   logic [CNT_W-1:0]       cnt_rd_dec;
   logic [CNT_W-1:0]       cnt_dec;
   logic [CNT_W-1:0]       cnt_inc;

   assign idx_wide  = {{ENT_W{1'b0}}, req.entry_index};
   assign req_entry = idx_wide[ENT_W-1:0];
   assign len_ext   = {{(LIM_W - LEN_W){1'b0}}, array_length};
   assign eff_len   = (len_ext < NUM_ENT_LIM) ? len_ext : NUM_ENT_LIM;
   assign in_range  = ({{(LIM_W - IDX_W){1'b0}}, req.entry_index} < eff_len);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign rd_snap    = hist_rd_data[HIST_W-1:VAL_W];
   assign rd_val     = hist_rd_data[VAL_W-1:0];
   assign hit        = (rd_snap <= query_ff);
   // one shared compare decides which half of the window survives
   assign lo_n       = hit ? (CNT_W'(mid_ff) + CNT_ONE) : lo_ff;
   assign hi_n       = hit ? hi_ff : CNT_W'(mid_ff);
   assign mid_sum    = ({1'b0, lo_n} + {1'b0, hi_n}) >> 1;
   assign first_sum  = {1'b0, cnt_rd_data} >> 1;
   assign cnt_rd_dec = cnt_rd_data - CNT_ONE;
   assign cnt_dec    = cnt_ff - CNT_ONE;
   assign cnt_inc    = cnt_ff + CNT_ONE;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      entry_in  = entry_ff;
      wval_in   = wval_ff;
      query_in  = query_ff;
      cnt_in    = cnt_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      found_in  = found_ff;
      hitval_in = hitval_ff;
      res_in    = res_ff;
      snap_in   = snap_ff;
      clr_in    = clr_ff;

      res_valid    = 1'b0;
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = entry_ff;
      cnt_wr_data  = cnt_inc;
      cnt_rd_addr  = req_entry;
      hist_wr_en   = 1'b0;
      hist_wr_addr = {entry_ff, cnt_ff[VER_W-1:0]};
      hist_wr_data = {snap_ff, wval_ff};
      hist_rd_addr = {entry_ff, mid_ff};

      case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
            clr_in      = clr_ff + ENT_W'(1);
            if (clr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req.kind;
               entry_in = req_entry;
               wval_in  = req.write_value;
               query_in = req.query_snapshot;
               res_in   = '0;
               state_in = ST_DONE;
               case (req.kind)
                  KIND_WRITE: begin
                     if (in_range) begin
                        state_in = ST_COUNT;
                     end else begin
                        res_in.status = STATUS_RANGE;
                     end
                  end
                  KIND_SNAP: begin
                     res_in.snapshot_taken = snap_ff;
                     if (snap_ff == SNAP_MAX) begin
                        res_in.status = STATUS_SAT;
                     end else begin
                        snap_in = snap_ff + SNAP_W'(1);
                     end
                  end
                  KIND_READ: begin
                     if (in_range) begin
                        state_in = ST_COUNT;
                     end else begin
                        res_in.read_value = READ_FAIL;
                        res_in.status     = STATUS_RANGE;
                     end
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            cnt_in = cnt_rd_data;
            if (kind_ff == KIND_WRITE) begin
               if (cnt_rd_data == '0) begin
                  hist_wr_en   = 1'b1;
                  hist_wr_addr = {entry_ff, {VER_W{1'b0}}};
                  cnt_wr_en    = 1'b1;
                  cnt_wr_data  = CNT_ONE;
                  state_in     = ST_DONE;
               end else begin
                  // latest pair decides between overwrite, append or a full status
                  hist_rd_addr = {entry_ff, cnt_rd_dec[VER_W-1:0]};
                  state_in     = ST_WR_CHECK;
               end
            end else begin
               found_in = 1'b0;
               lo_in    = '0;
               hi_in    = cnt_rd_data;
               if (cnt_rd_data == '0) begin
                  state_in = ST_DONE;
               end else begin
                  mid_in       = first_sum[VER_W-1:0];
                  hist_rd_addr = {entry_ff, first_sum[VER_W-1:0]};
                  state_in     = ST_SEARCH;
               end
            end
         end
         ST_WR_CHECK: begin
            state_in = ST_DONE;
            if (rd_snap == snap_ff) begin
               hist_wr_en   = 1'b1;
               hist_wr_addr = {entry_ff, cnt_dec[VER_W-1:0]};
            end else if (cnt_ff >= CNT_MAX) begin
               res_in.status = STATUS_FULL;
            end else begin
               hist_wr_en = 1'b1;
               cnt_wr_en  = 1'b1;
            end
         end
         ST_SEARCH: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (hit) begin
               found_in  = 1'b1;
               hitval_in = rd_val;
            end
            if (lo_n < hi_n) begin
               mid_in       = mid_sum[VER_W-1:0];
               hist_rd_addr = {entry_ff, mid_sum[VER_W-1:0]};
            end else begin
               if (hit) begin
                  res_in.read_value = rd_val;
               end else if (found_ff) begin
                  res_in.read_value = hitval_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         snap_ff  <= '0;
         clr_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         snap_ff  <= snap_in;
         clr_ff   <= clr_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      entry_ff  <= entry_in;
      wval_ff   <= wval_in;
      query_ff  <= query_in;
      cnt_ff    <= cnt_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      hitval_ff <= hitval_in;
      res_ff    <= res_in;
   end

   `VSA_ASSERT(a_busy_after_accept, clock, reset, accept |=> !req_ready, "item taken while busy")
   `VSA_ASSERT(a_search_window, clock, reset, (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff), "empty search window")
   `VSA_ASSERT(a_count_bound, clock, reset, cnt_wr_en |-> (cnt_wr_data <= CNT_MAX), "history count overflow")
   `VSA_ASSERT(a_snap_change, clock, reset, !$stable(snap_ff) |-> $past(accept && (req.kind == KIND_SNAP)), "counter moved without a snapshot item")

endmodule

FILE: rtl/versioned_snapshot_array_unit.sv
// top level of the versioned snapshot array: length register, output register
// and the two rams; uses vsa_pkg, vsa_seq, vsa_ram and assert_macros.svh
//
// req channel carries one item (write, snapshot or read) in tdata/tuser, and
// the rsp channel returns exactly one result item for every accepted item.
// csr_wr_en/csr_wr_data set the number of entries in use (reset 1024); write
// it only while no item is in flight.
// once an item is taken the sequencer runs on its own and req_tready
// stays low until the result is handed to the output register:
//   snapshot, unused kind or out-of-range index: straight to the hand-over
//   write: history count read, then latest pair read if the count is not zero
//   read: history count read, then at most ceil(log2(MAX_VERSIONS + 1)) search steps
// each search step waits on the registered read of the history ram and
// goes through the single shared compare.
// after reset the history counts are cleared one entry a cycle, so the block
// takes no item until every entry is cleared; the length register is written as ever.
// a result waiting in the output register while rsp_tready is low does not
// stop the next item from being taken; it holds only the following hand-over.
module versioned_snapshot_array_unit #(
   parameter int NUM_ENTRIES  = vsa_pkg::NUM_ENTRIES_DEF,
   parameter int MAX_VERSIONS = vsa_pkg::MAX_VERSIONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index [9:0], write_value [41:10], query_snapshot [57:42], zeros above
   input  logic [vsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind [1:0]
   input  logic [vsa_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_value [31:0], snapshot_taken [47:32], status [49:48], zeros above
   output logic [vsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [vsa_pkg::LEN_W-1:0]         csr_wr_data
);

   import vsa_pkg::*;

`include "assert_macros.svh"

   localparam int ENT_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int VER_W   = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
   localparam int CNT_W   = $clog2(MAX_VERSIONS + 1);
   localparam int HIST_AW = ENT_W + VER_W;
   localparam int PAD_W   = RSP_DATA_W - VAL_W - SNAP_W - STAT_W;

   logic [LEN_W-1:0]      array_length_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   req_type               req;
   res_type               res;
   logic                  res_valid;
   logic                  out_free;

   logic                  cnt_wr_en;
   logic [ENT_W-1:0]      cnt_wr_addr;
   logic [CNT_W-1:0]      cnt_wr_data;
   logic [ENT_W-1:0]      cnt_rd_addr;
   logic [CNT_W-1:0]      cnt_rd_data;
   logic                  hist_wr_en;
   logic [HIST_AW-1:0]    hist_wr_addr;
   logic [HIST_W-1:0]     hist_wr_data;
   logic [HIST_AW-1:0]    hist_rd_addr;
   logic [HIST_W-1:0]     hist_rd_data;

   // struct order: kind, entry_index, write_value, query_snapshot
   assign req = {req_tuser, req_tdata[9:0], req_tdata[41:10], req_tdata[57:42]};

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         array_length_ff <= LEN_RESET;
      end else if (csr_wr_en) begin
         array_length_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, res.status, res.snapshot_taken, res.read_value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   vsa_seq #(
      .NUM_ENTRIES  (NUM_ENTRIES),
      .MAX_VERSIONS (MAX_VERSIONS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req          (req),
      .array_length (array_length_ff),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .cnt_wr_en    (cnt_wr_en),
      .cnt_wr_addr  (cnt_wr_addr),
      .cnt_wr_data  (cnt_wr_data),
      .cnt_rd_addr  (cnt_rd_addr),
      .cnt_rd_data  (cnt_rd_data),
      .hist_wr_en   (hist_wr_en),
      .hist_wr_addr (hist_wr_addr),
      .hist_wr_data (hist_wr_data),
      .hist_rd_addr (hist_rd_addr),
      .hist_rd_data (hist_rd_data)
   );

   // per-entry number of stored pairs
   vsa_ram #(
      .WIDTH  (CNT_W),
      .DEPTH  (NUM_ENTRIES),
      .ADDR_W (ENT_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // pairs of snapshot number and value, one row of versions per entry
   vsa_ram #(
      .WIDTH  (HIST_W),
      .DEPTH  (1 << HIST_AW),
      .ADDR_W (HIST_AW)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   `VSA_ASSERT(a_no_overwrite, clock, reset, res_valid |-> out_free, "output register overrun")

endmodule

FILE: tb/sv/versioned_snapshot_array_unit_tb.sv
// testbench for versioned_snapshot_array_unit: directed and random item streams
// checked field by field against an in-bench model of the versioned store
// depends on vsa_pkg and the rtl of versioned_snapshot_array_unit
module versioned_snapshot_array_unit_tb;
   import vsa_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_STRETCH = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // entry_index [9:0], write_value [41:10], query_snapshot [57:42], zeros above
   logic [REQ_DATA_W-1:0] req_tdata;
   // kind [1:0]
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // read_value [31:0], snapshot_taken [47:32], status [49:48], zeros above
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [LEN_W-1:0]      csr_wr_data;

   // model state
   logic [SNAP_W-1:0] hist_snap [NUM_ENTRIES_DEF][MAX_VERSIONS_DEF];
   logic [VAL_W-1:0]  hist_val  [NUM_ENTRIES_DEF][MAX_VERSIONS_DEF];
   int unsigned       hist_cnt  [NUM_ENTRIES_DEF];
   logic [SNAP_W-1:0] snap_ctr;
   logic [LEN_W-1:0]  len_reg;

   res_type due_results [$];
   int      fail_count;
   int      stall_cycles;
   bit      steady_run;
   int      hold_request;
   int      hold_left;

   versioned_snapshot_array_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // applies one item to the model store and returns the result it yields
   function automatic res_type apply_item(input req_type it);
      res_type     r;
      int unsigned lim;
      int unsigned n;
      int unsigned i;
      r = '0;
      lim = (len_reg < NUM_ENTRIES_DEF) ? len_reg : NUM_ENTRIES_DEF;
      n = hist_cnt[it.entry_index];
      case (it.kind)
         KIND_WRITE: begin
            if (it.entry_index >= lim) begin
               r.status = STATUS_RANGE;
            end else if (n > 0 && hist_snap[it.entry_index][n-1] == snap_ctr) begin
               hist_val[it.entry_index][n-1] = it.write_value;
            end else if (n >= MAX_VERSIONS_DEF) begin
               r.status = STATUS_FULL;
            end else begin
               hist_snap[it.entry_index][n] = snap_ctr;
               hist_val[it.entry_index][n] = it.write_value;
               hist_cnt[it.entry_index] = n + 1;
            end
         end
         KIND_SNAP: begin
            r.snapshot_taken = snap_ctr;
            if (snap_ctr == SNAP_MAX) r.status = STATUS_SAT;
            else snap_ctr = snap_ctr + 1'b1;
         end
         KIND_READ: begin
            if (it.entry_index >= lim) begin
               r.read_value = READ_FAIL;
               r.status = STATUS_RANGE;
            end else begin
               // numbers rise strictly, so the last match is the newest at or below
               for (i = 0; i < n; i++)
                  if (hist_snap[it.entry_index][i] <= it.query_snapshot)
                     r.read_value = hist_val[it.entry_index][i];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type item_of(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
                                       input logic [VAL_W-1:0] v, input logic [SNAP_W-1:0] q);
      req_type it;
      it.kind = k;
      it.entry_index = idx;
      it.write_value = v;
      it.query_snapshot = q;
      return it;
   endfunction

   // mostly writes and reads to a few busy entries so histories build up and fill
   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) it.kind = KIND_WRITE;
      else if (pick < 58) it.kind = KIND_SNAP;
      else if (pick < 95) it.kind = KIND_READ;
      else it.kind = KIND_UNUSED;
      if ($urandom_range(99) < 75) begin
         case ($urandom_range(7))
            0: it.entry_index = 10'd0;
            1: it.entry_index = 10'd1;
            2: it.entry_index = 10'd2;
            3: it.entry_index = 10'd3;
            4: it.entry_index = 10'd5;
            5: it.entry_index = 10'd511;
            6: it.entry_index = 10'd1022;
            default: it.entry_index = 10'd1023;
         endcase
      end else begin
         it.entry_index = IDX_W'($urandom_range(1023));
      end
      it.write_value = $urandom;
      if ($urandom_range(99) < 65) it.query_snapshot = SNAP_W'($urandom_range(snap_ctr + 1));
      else it.query_snapshot = SNAP_W'($urandom);
      return it;
   endfunction

   task automatic send_item(input req_type it);
      while (!steady_run && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, it.query_snapshot, it.write_value, it.entry_index};
      req_tuser  <= it.kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due_results.push_back(apply_item(it));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      len_reg = v;
   endtask

   task automatic test_basic();
      send_item(item_of(KIND_READ, 10'd0, 32'd0, 16'd0));          // empty history
      send_item(item_of(KIND_WRITE, 10'd0, 32'h8000_0000, 16'd0));
      send_item(item_of(KIND_WRITE, 10'd1023, 32'h7FFF_FFFF, 16'hFFFF));
      send_item(item_of(KIND_READ, 10'd0, 32'd0, 16'd0));
      send_item(item_of(KIND_READ, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF));
      send_item(item_of(KIND_SNAP, 10'd0, 32'd0, 16'd0));
      send_item(item_of(KIND_WRITE, 10'd0, 32'hFFFF_FFFF, 16'd0));
      send_item(item_of(KIND_WRITE, 10'd0, 32'd5, 16'd0));         // same number, overwrite
      send_item(item_of(KIND_READ, 10'd0, 32'd0, 16'd0));
      send_item(item_of(KIND_READ, 10'd0, 32'd0, 16'd1));
      send_item(item_of(KIND_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF));
   endtask

   task automatic test_length_register();
      write_length(11'd0);
      send_item(item_of(KIND_WRITE, 10'd0, 32'd9, 16'd0));
      send_item(item_of(KIND_READ, 10'd0, 32'd0, 16'd0));
      write_length(11'd1);
      send_item(item_of(KIND_READ, 10'd0, 32'd0, 16'd1));
      send_item(item_of(KIND_READ, 10'd1, 32'd0, 16'd1));
      write_length(11'd2047);
      send_item(item_of(KIND_READ, 10'd1023, 32'd0, 16'hFFFF));
      write_length(LEN_RESET);
   endtask

   task automatic test_history_full();
      int                i;
      logic [SNAP_W-1:0] first;
      first = snap_ctr;
      for (i = 0; i < MAX_VERSIONS_DEF - 1; i++) begin
         send_item(item_of(KIND_WRITE, 10'd7, i * 3 - 7, 16'd0));
         send_item(item_of(KIND_SNAP, 10'd7, 32'd0, 16'd0));
      end
      send_item(item_of(KIND_WRITE, 10'd7, 32'd100, 16'd0));
      send_item(item_of(KIND_WRITE, 10'd7, 32'd101, 16'd0));       // latest still writable
      send_item(item_of(KIND_SNAP, 10'd7, 32'd0, 16'd0));
      send_item(item_of(KIND_WRITE, 10'd7, 32'd102, 16'd0));       // history full
      send_item(item_of(KIND_READ, 10'd7, 32'd0, snap_ctr));
      send_item(item_of(KIND_READ, 10'd7, 32'd0, first - 1'b1));
      send_item(item_of(KIND_READ, 10'd7, 32'd0, first));
      send_item(item_of(KIND_READ, 10'd7, 32'd0, first + 16'd7));
   endtask

   task automatic test_backpressure();
      int i;
      wait_idle();
      hold_request = HOLD_STRETCH;
      for (i = 0; i < 24; i++) send_item(random_item());
      // sender stops here until every result is back
      wait_idle();
   endtask

   task automatic test_random();
      int i;
      for (i = 0; i < 130; i++) send_item(random_item());
      wait_idle();
      steady_run = 1'b1;
      for (i = 0; i < 90; i++) send_item(random_item());
      wait_idle();
      steady_run = 1'b0;
      write_length(11'd600);
      for (i = 0; i < 60; i++) send_item(random_item());
      write_length(11'd2047);
      for (i = 0; i < 50; i++) send_item(random_item());
      write_length(LEN_W'($urandom_range(2047)));
      for (i = 0; i < 50; i++) send_item(random_item());
      write_length(LEN_RESET);
   endtask

   // result side: random idling, plus a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= steady_run ? 1'b1 : ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin : check_rsp
      res_type got;
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value     = rsp_tdata[31:0];
         got.snapshot_taken = rsp_tdata[47:32];
         got.status         = rsp_tdata[49:48];
         if (due_results.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (got.read_value !== want.read_value) begin
               $error("read_value expected %0d got %0d", want.read_value, got.read_value);
               fail_count++;
            end
            if (got.snapshot_taken !== want.snapshot_taken) begin
               $error("snapshot_taken expected %0d got %0d",
                      want.snapshot_taken, got.snapshot_taken);
               fail_count++;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, got.status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("versioned_snapshot_array_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      fail_count   = 0;
      stall_cycles = 0;
      steady_run   = 1'b0;
      hold_request = 0;
      hold_left    = 0;
      snap_ctr     = '0;
      len_reg      = LEN_RESET;
      foreach (hist_cnt[e]) hist_cnt[e] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_basic();
      test_length_register();
      test_history_full();
      test_backpressure();
      test_random();
      wait_idle();
      repeat (20) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d result items never arrived", due_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("versioned_snapshot_array_unit_tb: clean");
      end else begin
         $display("versioned_snapshot_array_unit_tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/vsa_pkg.sv
rtl/vsa_ram.sv
rtl/vsa_seq.sv
rtl/versioned_snapshot_array_unit.sv
tb/sv/versioned_snapshot_array_unit_tb.sv
